/* hdl/apm_pkg.sv */
// Package with shared types, constants and op codes of the peak meter.
`timescale 1ns / 1ps
package apm_pkg;
    localparam int CHANNELS    = 16;
    localparam int CH_W        = 4;
    localparam int SAMPLE_BITS = 24;
    localparam int DB_W        = 17;
    localparam logic signed [DB_W-1:0] FLOOR_DB = -17'sd65536;
    localparam logic [18:0] DB_PER_LOG2_Q16 = 19'd394566;

    localparam logic [2:0] OP_SAMPLE     = 3'd0;
    localparam logic [2:0] OP_BLOCK_END  = 3'd1;
    localparam logic [2:0] OP_READ       = 3'd2;
    localparam logic [2:0] OP_RESET      = 3'd3;
    localparam logic [2:0] OP_RESET_HOLD = 3'd4;

    localparam logic REG_FALLOFF = 1'b0;
    localparam logic REG_ACTIVE  = 1'b1;

    typedef struct packed {
        logic                   start;
        logic [SAMPLE_BITS-1:0] peak;
    } log_req_t;

    typedef struct packed {
        logic                   done;
        logic signed [DB_W-1:0] db;
    } log_rsp_t;
endpackage

/* hdl/apm_log_unit.sv */
// Iterative peak-to-dB converter: one squaring per cycle, then one multiply.
`timescale 1ns / 1ps
module apm_log_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  apm_pkg::log_req_t req,
    output apm_pkg::log_rsp_t rsp
);
    typedef enum logic [4:0] {
        L_IDLE = 5'b00001,
        L_NORM = 5'b00010,
        L_SQ   = 5'b00100,
        L_MUL  = 5'b01000,
        L_DONE = 5'b10000
    } lstate_t;

    lstate_t state_reg, state_next;
    logic [apm_pkg::SAMPLE_BITS-1:0] p_reg;
    logic [4:0]  e_reg, e_next;
    logic [31:0] x_reg, x_next;
    logic [15:0] frac_reg, frac_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [44:0] prod_reg, prod_next;
    logic        zero_reg, zero_next;
    logic signed [apm_pkg::DB_W-1:0] db_reg, db_next;

    logic [63:0] sq;
    logic [31:0] sq30;
    logic [4:0]  msb;
    logic [22:0] l2, span_q16;
    logic [45:0] rnd;
    logic [21:0] mag;

    always_comb begin
        msb = '0;
        for (int i = 0; i < apm_pkg::SAMPLE_BITS; i++) begin
            if (p_reg[i]) begin
                msb = 5'(i);
            end
        end
    end

    assign sq   = 64'(x_reg) * 64'(x_reg);
    assign sq30 = sq[61:30];
    assign l2   = {2'b00, e_reg, frac_reg};
    assign span_q16 = (23'(apm_pkg::SAMPLE_BITS - 1) << 16) > l2 ?
                      (23'(apm_pkg::SAMPLE_BITS - 1) << 16) - l2 : '0;
    assign rnd  = {1'b0, prod_reg} + (46'd1 << 23);
    assign mag  = rnd[45:24];

    always_comb begin
        state_next = state_reg;
        e_next = e_reg;
        x_next = x_reg;
        frac_next = frac_reg;
        cnt_next = cnt_reg;
        prod_next = prod_reg;
        zero_next = zero_reg;
        db_next = db_reg;
        case (state_reg)
            L_IDLE: begin
                if (req.start) begin
                    state_next = L_NORM;
                end
            end
            L_NORM: begin
                zero_next = (p_reg == '0);
                e_next = msb;
                x_next = 32'({8'd0, p_reg} << (5'd30 - msb));
                frac_next = '0;
                cnt_next = '0;
                state_next = L_SQ;
            end
            L_SQ: begin
                if (sq30[31]) begin
                    frac_next = {frac_reg[14:0], 1'b1};
                    x_next = {1'b0, sq30[31:1]};
                end else begin
                    frac_next = {frac_reg[14:0], 1'b0};
                    x_next = sq30;
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15) begin
                    state_next = L_MUL;
                end
            end
            L_MUL: begin
                // Product of the distance from full scale and dB per octave.
                prod_next = 45'(span_q16) * 45'(apm_pkg::DB_PER_LOG2_Q16);
                state_next = L_DONE;
            end
            L_DONE: begin
                if (zero_reg || mag >= 22'd65536) begin
                    db_next = apm_pkg::FLOOR_DB;
                end else begin
                    db_next = -$signed({1'b0, mag[15:0]});
                end
                state_next = L_IDLE;
            end
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
        end else begin
            state_reg <= state_next;
        end
        if (state_reg == L_IDLE && req.start) begin
            p_reg <= req.peak;
        end
        e_reg <= e_next;
        x_reg <= x_next;
        frac_reg <= frac_next;
        cnt_reg <= cnt_next;
        prod_reg <= prod_next;
        zero_reg <= zero_next;
        db_reg <= db_next;
    end

    assign rsp.done = (state_reg == L_DONE);
    assign rsp.db   = db_next;
endmodule

/* hdl/audio_peak_meter_with_falloff_unit.sv */
// Peak meter with falloff and hold: samples, resets and reads of an unused channel
// are handled in S_IDLE; a read of a channel in use goes through normalize, 16 squarings
// in the shared log unit, multiply, round, then merge; block end walks the channels
// in use one per cycle.
// One request is processed at a time; a result waits in an output register.
// Synchronous active-low reset floors all levels and sets reset pending.
`timescale 1ns / 1ps
module audio_peak_meter_with_falloff_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_op,
    input  logic [3:0]                    s_channel,
    input  logic signed [23:0]            s_sample,
    input  logic [13:0]                   s_frame_count,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [3:0]                    m_channel_res,
    output logic signed [16:0]            m_level,
    output logic signed [16:0]            m_max_level,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [24:0]                   cfg_data
);
    localparam int N = apm_pkg::CHANNELS;
    localparam int W = apm_pkg::DB_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_BLOCK = 5'b00010,
        S_LOG   = 5'b00100,
        S_MERGE = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg;
    logic [23:0] peak_reg [N];
    logic signed [W-1:0] lvl_reg [N];
    logic signed [W-1:0] hold_reg [N];
    logic [31:0] acc_reg [N];
    logic [N-1:0] lvl_floor_reg, hold_floor_reg, acc_ok_reg, peak_ok_reg;
    logic pend_reg;
    logic [24:0] falloff_reg;
    logic [4:0]  active_reg;
    logic [3:0]  ch_reg;
    logic [38:0] inc_reg;
    logic [4:0]  idx_reg;
    logic        out_v_reg;
    logic [3:0]  out_ch_reg;
    logic signed [W-1:0] out_lvl_reg, out_hold_reg;
    logic signed [W-1:0] decayed_reg;

    apm_pkg::log_req_t lreq;
    apm_pkg::log_rsp_t lrsp;

    logic [4:0]  n_use;
    logic [23:0] mag;
    logic [31:0] cur_acc, blk_acc;
    logic [39:0] sum;
    logic signed [W-1:0] cur_lvl, cur_hold, merged;
    logic signed [W+15:0] dec;

    assign n_use = active_reg > 5'(N) ? 5'(N) : active_reg;
    assign mag = s_sample[23] ? 24'(-s_sample) : s_sample;
    assign cur_acc  = acc_ok_reg[ch_reg] ? acc_reg[ch_reg] : '0;
    assign cur_lvl  = lvl_floor_reg[ch_reg] ? apm_pkg::FLOOR_DB : lvl_reg[ch_reg];
    assign cur_hold = hold_floor_reg[ch_reg] ? apm_pkg::FLOOR_DB : hold_reg[ch_reg];
    assign blk_acc  = acc_ok_reg[idx_reg[3:0]] ? acc_reg[idx_reg[3:0]] : '0;
    assign sum = 40'(blk_acc) + 40'(inc_reg);
    assign dec = (W+16)'(cur_lvl) - (W+16)'($signed({1'b0, cur_acc[31:16]}));
    assign merged = lrsp.db > decayed_reg ? lrsp.db : decayed_reg;

    // The log unit starts only when the read request is actually accepted.
    assign lreq.start = s_valid && s_ready && s_op == apm_pkg::OP_READ
                        && (5'(s_channel) < n_use);
    assign lreq.peak  = (peak_ok_reg[s_channel]) ? peak_reg[s_channel] : '0;

    apm_log_unit u_log (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (lreq),
        .rsp     (lrsp)
    );

    assign s_ready   = (state_reg == S_IDLE) && !out_v_reg;
    assign cfg_ready = 1'b1;
    assign m_valid       = out_v_reg;
    assign m_channel_res = out_ch_reg;
    assign m_level       = out_lvl_reg;
    assign m_max_level   = out_hold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            lvl_floor_reg <= '1;
            hold_floor_reg <= '1;
            acc_ok_reg <= '0;
            peak_ok_reg <= '0;
            pend_reg <= 1'b1;
            falloff_reg <= '0;
            active_reg <= 5'd16;
            out_v_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == apm_pkg::REG_FALLOFF) begin
                    falloff_reg <= cfg_data;
                end else begin
                    active_reg <= cfg_data[4:0];
                end
            end
            if (out_v_reg && m_ready) begin
                out_v_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        ch_reg <= s_channel;
                        case (s_op)
                            apm_pkg::OP_SAMPLE: begin
                                if (5'(s_channel) < n_use && (!peak_ok_reg[s_channel]
                                    || mag > peak_reg[s_channel])) begin
                                    peak_reg[s_channel] <= mag;
                                    peak_ok_reg[s_channel] <= 1'b1;
                                end
                            end
                            apm_pkg::OP_BLOCK_END: begin
                                inc_reg <= 39'(falloff_reg) * 39'(s_frame_count);
                                idx_reg <= '0;
                                state_reg <= S_BLOCK;
                            end
                            apm_pkg::OP_READ: begin
                                if (5'(s_channel) < n_use) begin
                                    state_reg <= S_LOG;
                                end else begin
                                    out_v_reg <= 1'b1;
                                    out_ch_reg <= s_channel;
                                    out_lvl_reg <= apm_pkg::FLOOR_DB;
                                    out_hold_reg <= apm_pkg::FLOOR_DB;
                                end
                            end
                            apm_pkg::OP_RESET: begin
                                pend_reg <= 1'b1;
                                lvl_floor_reg <= '1;
                            end
                            apm_pkg::OP_RESET_HOLD: begin
                                hold_floor_reg <= '1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_BLOCK: begin
                    if (idx_reg >= n_use) begin
                        pend_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end else begin
                        if (pend_reg) begin
                            peak_ok_reg[idx_reg[3:0]] <= 1'b0;
                            acc_ok_reg[idx_reg[3:0]] <= 1'b0;
                        end else begin
                            acc_reg[idx_reg[3:0]] <= sum[39:32] != '0 ? '0 : sum[31:0];
                            acc_ok_reg[idx_reg[3:0]] <= 1'b1;
                        end
                        idx_reg <= idx_reg + 5'd1;
                    end
                end
                S_LOG: begin
                    // Decay is applied while the log unit works.
                    if (cur_lvl > apm_pkg::FLOOR_DB && falloff_reg != '0) begin
                        decayed_reg <= dec < (W+16)'(apm_pkg::FLOOR_DB) ?
                                       apm_pkg::FLOOR_DB : W'(dec);
                    end else begin
                        decayed_reg <= apm_pkg::FLOOR_DB;
                    end
                    if (lrsp.done) begin
                        state_reg <= S_MERGE;
                    end
                end
                S_MERGE: begin
                    lvl_reg[ch_reg] <= merged;
                    lvl_floor_reg[ch_reg] <= 1'b0;
                    if (merged > cur_hold) begin
                        hold_reg[ch_reg] <= merged;
                        out_hold_reg <= merged;
                    end else begin
                        hold_reg[ch_reg] <= cur_hold;
                        out_hold_reg <= cur_hold;
                    end
                    hold_floor_reg[ch_reg] <= 1'b0;
                    acc_ok_reg[ch_reg] <= 1'b0;
                    peak_ok_reg[ch_reg] <= 1'b0;
                    out_lvl_reg <= merged;
                    out_ch_reg <= ch_reg;
                    out_v_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
